@@ hw/rtl/lfpd_pkg.sv @@
`default_nettype none
// ============================================================================
// lfpd_pkg
// Shared types, constants and tables of the line-follow PD steering block.
// ============================================================================

package lfpd_pkg;

    localparam int RAW_W     = 10;
    localparam int NUM_SENS  = 6;
    localparam int GAIN_W    = 8;
    localparam int MS_W      = 16;
    localparam int ELAPSED_W = 8;
    localparam int ERR_W     = 16;
    localparam int ACC_W     = 32;
    localparam int OPA_W     = 17;
    localparam int OPB_W     = 10;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam logic [7:0]  LOST_LIMIT  = 8'd3;
    localparam logic [7:0]  LOST_MAX    = 8'd255;
    localparam logic [7:0]  PWM_MAX     = 8'd255;
    // right side: round(|cmd| * 16 / 15 / 256) = ((|cmd| + 120) >> 4) / 15
    localparam logic [31:0] RIGHT_BIAS  = 32'd120;
    localparam logic [27:0] RIGHT_LIMIT = 28'd3840;
    localparam logic [11:0] RECIP15     = 12'd2185;

    localparam logic signed [3:0] SENSOR_WEIGHT [NUM_SENS] =
        '{-4'sd5, -4'sd3, -4'sd1, 4'sd1, 4'sd3, 4'sd5};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_THRESHOLD = 4'd0,
        REG_PROP_GAIN      = 4'd1,
        REG_DERIV_GAIN     = 4'd2,
        REG_SMOOTH_ALPHA   = 4'd3,
        REG_TURN_SLOWDOWN  = 4'd4,
        REG_BASE_SPEED     = 4'd5,
        REG_SEARCH_SPEED   = 4'd6,
        REG_STALE_LIMIT_MS = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic [RAW_W-1:0]  line_threshold;
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] smooth_alpha;
        logic [GAIN_W-1:0] turn_slowdown;
        logic [GAIN_W-1:0] base_speed;
        logic [GAIN_W-1:0] search_speed;
        logic [MS_W-1:0]   stale_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic                    en;
        logic                    clr;
        logic                    use_prod;
        logic signed [OPA_W-1:0] a;
        logic signed [OPB_W-1:0] b;
        logic signed [ACC_W-1:0] addend;
    } t_mac_ctl;

    // round(w * 256 / c), halves up, for |weighted sum| w and hit count c
    function automatic logic [11:0] err_mag(input logic [3:0] w, input logic [2:0] c);
        logic [11:0] q;
        q = 12'd0;
        case (c)
            3'd1: q = {w, 8'b0};
            3'd2: q = {1'b0, w, 7'b0};
            3'd4: q = {2'b0, w, 6'b0};
            3'd3: begin
                case (w)
                    4'd1:    q = 12'd85;
                    4'd2:    q = 12'd171;
                    4'd3:    q = 12'd256;
                    4'd4:    q = 12'd341;
                    4'd5:    q = 12'd427;
                    4'd6:    q = 12'd512;
                    4'd7:    q = 12'd597;
                    4'd8:    q = 12'd683;
                    4'd9:    q = 12'd768;
                    default: q = 12'd0;
                endcase
            end
            3'd5: begin
                case (w)
                    4'd1:    q = 12'd51;
                    4'd2:    q = 12'd102;
                    4'd3:    q = 12'd154;
                    4'd4:    q = 12'd205;
                    4'd5:    q = 12'd256;
                    4'd6:    q = 12'd307;
                    4'd7:    q = 12'd358;
                    4'd8:    q = 12'd410;
                    4'd9:    q = 12'd461;
                    default: q = 12'd0;
                endcase
            end
            3'd6: begin
                case (w)
                    4'd1:    q = 12'd43;
                    4'd2:    q = 12'd85;
                    4'd3:    q = 12'd128;
                    4'd4:    q = 12'd171;
                    4'd5:    q = 12'd213;
                    4'd6:    q = 12'd256;
                    4'd7:    q = 12'd299;
                    4'd8:    q = 12'd341;
                    4'd9:    q = 12'd384;
                    default: q = 12'd0;
                endcase
            end
            default: q = 12'd0;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lfpd_if.sv @@
`default_nettype none
// ============================================================================
// lfpd interfaces
// Request channels of the steering block: sensor input, motor output and
// configuration write.
// ============================================================================

interface lfpd_in_if;
    logic                        valid;
    logic                        ready;
    logic [lfpd_pkg::RAW_W-1:0]  raw_0;
    logic [lfpd_pkg::RAW_W-1:0]  raw_1;
    logic [lfpd_pkg::RAW_W-1:0]  raw_2;
    logic [lfpd_pkg::RAW_W-1:0]  raw_3;
    logic [lfpd_pkg::RAW_W-1:0]  raw_4;
    logic [lfpd_pkg::RAW_W-1:0]  raw_5;
    logic                        fresh;
    logic [lfpd_pkg::ELAPSED_W-1:0] elapsed_ms;

    modport source (output valid, raw_0, raw_1, raw_2, raw_3, raw_4, raw_5,
                    fresh, elapsed_ms, input ready);
    modport sink   (input valid, raw_0, raw_1, raw_2, raw_3, raw_4, raw_5,
                    fresh, elapsed_ms, output ready);
endinterface

interface lfpd_out_if;
    logic       valid;
    logic       ready;
    logic       left_reverse;
    logic [7:0] left_duty;
    logic       right_reverse;
    logic [7:0] right_duty;
    logic       stopped;
    logic       searching;

    modport source (output valid, left_reverse, left_duty, right_reverse, right_duty,
                    stopped, searching, input ready);
    modport sink   (input valid, left_reverse, left_duty, right_reverse, right_duty,
                    stopped, searching, output ready);
endinterface

interface lfpd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lfpd_pkg::CFG_IDX_W-1:0]    index;
    logic [lfpd_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lfpd_cfg_regs.sv @@
`default_nettype none
// ============================================================================
// lfpd_cfg_regs
// Configuration register file; writes beyond the last register are dropped.
// ============================================================================

module lfpd_cfg_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    lfpd_cfg_if.sink            i_cfg,
    output lfpd_pkg::t_cfg      o_cfg
);

    lfpd_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_threshold <= 10'd900;
            r_cfg.prop_gain      <= 8'd25;
            r_cfg.deriv_gain     <= 8'd65;
            r_cfg.smooth_alpha   <= 8'd115;
            r_cfg.turn_slowdown  <= 8'd18;
            r_cfg.base_speed     <= 8'd150;
            r_cfg.search_speed   <= 8'd110;
            r_cfg.stale_limit_ms <= 16'd120;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lfpd_pkg::REG_LINE_THRESHOLD: r_cfg.line_threshold <= i_cfg.data[9:0];
                lfpd_pkg::REG_PROP_GAIN:      r_cfg.prop_gain      <= i_cfg.data[7:0];
                lfpd_pkg::REG_DERIV_GAIN:     r_cfg.deriv_gain     <= i_cfg.data[7:0];
                lfpd_pkg::REG_SMOOTH_ALPHA:   r_cfg.smooth_alpha   <= i_cfg.data[7:0];
                lfpd_pkg::REG_TURN_SLOWDOWN:  r_cfg.turn_slowdown  <= i_cfg.data[7:0];
                lfpd_pkg::REG_BASE_SPEED:     r_cfg.base_speed     <= i_cfg.data[7:0];
                lfpd_pkg::REG_SEARCH_SPEED:   r_cfg.search_speed   <= i_cfg.data[7:0];
                lfpd_pkg::REG_STALE_LIMIT_MS: r_cfg.stale_limit_ms <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lfpd_mac.sv @@
`default_nettype none
// ============================================================================
// lfpd_mac
// Shared multiply-accumulate unit: acc <= (clr ? 0 : acc) + (a * b | addend).
// ============================================================================

module lfpd_mac (
    input  wire logic                                  i_clk,
    input  wire lfpd_pkg::t_mac_ctl                    i_ctl,
    output logic signed [lfpd_pkg::ACC_W-1:0]          o_acc
);

    localparam int PROD_W = lfpd_pkg::OPA_W + lfpd_pkg::OPB_W;

    logic signed [PROD_W-1:0]          prod;
    logic signed [lfpd_pkg::ACC_W-1:0] prod_ext;
    logic signed [lfpd_pkg::ACC_W-1:0] lhs;
    logic signed [lfpd_pkg::ACC_W-1:0] rhs;
    logic signed [lfpd_pkg::ACC_W-1:0] r_acc;

    always_comb begin
        prod     = i_ctl.a * i_ctl.b;
        prod_ext = {{(lfpd_pkg::ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
        lhs      = i_ctl.clr ? '0 : r_acc;
        rhs      = i_ctl.use_prod ? prod_ext : i_ctl.addend;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= lhs + rhs;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

@@ hw/rtl/lfpd_seq.sv @@
`default_nettype none
// ============================================================================
// lfpd_seq
// Sequencer: frame timing, line error, mode tracking, filter and PD steps
// on the shared MAC, and the motor output register.
// ============================================================================

module lfpd_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lfpd_pkg::t_cfg                i_cfg,
    lfpd_in_if.sink                            i_in,
    lfpd_out_if.source                         o_out,
    output lfpd_pkg::t_mac_ctl                 o_mac,
    input  wire logic signed [lfpd_pkg::ACC_W-1:0] i_acc
);

    localparam int ACC_W = lfpd_pkg::ACC_W;
    localparam int ERR_W = lfpd_pkg::ERR_W;
    localparam int NS    = lfpd_pkg::NUM_SENS;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_ERR, S_MIX0, S_MIX1, S_FILT, S_P, S_D,
        S_B0, S_B1, S_L, S_R, S_CMD, S_OUT
    } t_state;

    t_state                         r_state;
    logic [lfpd_pkg::RAW_W-1:0]     r_reading [NS];
    logic [lfpd_pkg::MS_W-1:0]      r_ms;
    logic [NS-1:0]                  r_hit;
    logic                           r_stale;
    logic signed [ERR_W-1:0]        r_err;
    logic signed [ERR_W-1:0]        r_filt;
    logic signed [ERR_W-1:0]        r_prev;
    logic signed [ERR_W-1:0]        r_last;
    logic signed [ERR_W:0]          r_diff;
    logic [ERR_W:0]                 r_absf;
    logic signed [ACC_W-1:0]        r_corr;
    logic signed [ACC_W-1:0]        r_cmd_l;
    logic signed [ACC_W-1:0]        r_cmd_r;
    logic [7:0]                     r_lost;
    logic                           r_tracking;
    logic                           r_out_valid;
    logic                           r_left_rev;
    logic [7:0]                     r_left_duty;
    logic                           r_right_rev;
    logic [7:0]                     r_right_duty;
    logic                           r_stopped;
    logic                           r_searching;

    logic                           in_acc;
    logic                           out_free;
    logic [lfpd_pkg::MS_W:0]        ms_sum;
    logic [lfpd_pkg::MS_W-1:0]      n_ms;
    logic [NS-1:0]                  hit;
    logic signed [4:0]              weighted;
    logic [2:0]                     hit_cnt;
    logic [4:0]                     abs_w;
    logic [11:0]                    mag;
    logic signed [ERR_W-1:0]        n_err;
    logic [7:0]                     n_lost;
    logic                           n_track;
    logic signed [ACC_W-1:0]        spin;
    logic                           mix_neg;
    logic [ACC_W-1:0]               mix_abs;
    logic [ACC_W-1:0]               mix_rnd;
    logic signed [ERR_W-1:0]        n_filt;
    logic signed [ERR_W:0]          n_diff;
    logic [ERR_W:0]                 n_absf;
    logic [ACC_W-1:0]               l_abs;
    logic [ACC_W-1:0]               l_rnd;
    logic [7:0]                     l_pwm;
    logic [ACC_W-1:0]               rt_abs;
    logic [ACC_W-1:0]               rt_biased;
    logic [27:0]                    rt_y;
    logic [23:0]                    rt_q;
    logic [7:0]                     rt_pwm;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.left_reverse  = r_left_rev;
    assign o_out.left_duty     = r_left_duty;
    assign o_out.right_reverse = r_right_rev;
    assign o_out.right_duty    = r_right_duty;
    assign o_out.stopped       = r_stopped;
    assign o_out.searching     = r_searching;

    // frame timing
    always_comb begin
        ms_sum = {1'b0, r_ms} + {9'b0, i_in.elapsed_ms};
        if (i_in.fresh) begin
            n_ms = '0;
        end else if (ms_sum[lfpd_pkg::MS_W]) begin
            n_ms = '1;
        end else begin
            n_ms = ms_sum[lfpd_pkg::MS_W-1:0];
        end
    end

    // line error from hit pattern
    always_comb begin
        for (int i = 0; i < NS; i++) begin
            hit[i] = r_reading[i] > i_cfg.line_threshold;
        end
        weighted = '0;
        hit_cnt  = '0;
        for (int i = 0; i < NS; i++) begin
            if (r_hit[i]) begin
                weighted = weighted + {lfpd_pkg::SENSOR_WEIGHT[i][3],
                                       lfpd_pkg::SENSOR_WEIGHT[i]};
                hit_cnt  = hit_cnt + 3'd1;
            end
        end
        abs_w  = weighted[4] ? 5'(-weighted) : weighted;
        mag    = lfpd_pkg::err_mag(abs_w[3:0], hit_cnt);
        n_err  = weighted[4] ? (16'd0 - {4'b0, mag}) : {4'b0, mag};
        n_lost = (r_lost == lfpd_pkg::LOST_MAX) ? r_lost : r_lost + 8'd1;
        n_track = (hit_cnt != 3'd0) || (r_tracking && (n_lost < lfpd_pkg::LOST_LIMIT));
        spin   = $signed({16'b0, i_cfg.search_speed, 8'b0});
    end

    // filter rounding and saturation
    always_comb begin
        mix_neg = i_acc[ACC_W-1];
        mix_abs = mix_neg ? ACC_W'(-i_acc) : ACC_W'(i_acc);
        mix_rnd = (mix_abs + 32'd128) >> 8;
        if (!mix_neg && mix_rnd > 32'd32767) begin
            n_filt = 16'sh7FFF;
        end else if (mix_neg && mix_rnd > 32'd32768) begin
            n_filt = 16'sh8000;
        end else if (mix_neg) begin
            n_filt = 16'd0 - mix_rnd[15:0];
        end else begin
            n_filt = mix_rnd[15:0];
        end
        n_diff = {n_filt[ERR_W-1], n_filt} - {r_prev[ERR_W-1], r_prev};
        n_absf = n_filt[ERR_W-1] ? (17'd0 - {1'b1, n_filt}) : {1'b0, n_filt};
    end

    // motor command to direction and duty
    always_comb begin
        l_abs     = r_cmd_l[ACC_W-1] ? ACC_W'(-r_cmd_l) : ACC_W'(r_cmd_l);
        l_rnd     = (l_abs + 32'd128) >> 8;
        l_pwm     = (l_rnd > 32'd255) ? lfpd_pkg::PWM_MAX : l_rnd[7:0];
        rt_abs    = r_cmd_r[ACC_W-1] ? ACC_W'(-r_cmd_r) : ACC_W'(r_cmd_r);
        rt_biased = rt_abs + lfpd_pkg::RIGHT_BIAS;
        rt_y      = rt_biased[31:4];
        rt_q      = rt_y[11:0] * lfpd_pkg::RECIP15;
        rt_pwm    = (rt_y >= lfpd_pkg::RIGHT_LIMIT) ? lfpd_pkg::PWM_MAX : rt_q[22:15];
    end

    // MAC schedule
    always_comb begin
        o_mac          = '0;
        o_mac.use_prod = 1'b1;
        case (r_state)
            S_MIX0: begin
                o_mac.en  = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = {r_filt[ERR_W-1], r_filt};
                o_mac.b   = {2'b0, i_cfg.smooth_alpha};
            end
            S_MIX1: begin
                o_mac.en = 1'b1;
                o_mac.a  = {r_err[ERR_W-1], r_err};
                o_mac.b  = {1'b0, 9'd256 - {1'b0, i_cfg.smooth_alpha}};
            end
            S_P: begin
                o_mac.en  = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = {r_filt[ERR_W-1], r_filt};
                o_mac.b   = {2'b0, i_cfg.prop_gain};
            end
            S_D: begin
                o_mac.en = 1'b1;
                o_mac.a  = r_diff;
                o_mac.b  = {2'b0, i_cfg.deriv_gain};
            end
            S_B0: begin
                o_mac.en  = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = {9'b0, i_cfg.base_speed};
                o_mac.b   = 10'sd256;
            end
            S_B1: begin
                o_mac.en = 1'b1;
                o_mac.a  = r_absf;
                o_mac.b  = 10'd0 - {2'b0, i_cfg.turn_slowdown};
            end
            S_L: begin
                o_mac.en       = 1'b1;
                o_mac.use_prod = 1'b0;
                o_mac.addend   = -r_corr;
            end
            S_R: begin
                o_mac.en       = 1'b1;
                o_mac.use_prod = 1'b0;
                o_mac.addend   = r_corr <<< 1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            for (int i = 0; i < NS; i++) begin
                r_reading[i] <= '0;
            end
            r_ms        <= '1;
            r_filt      <= '0;
            r_prev      <= '0;
            r_last      <= '0;
            r_lost      <= '0;
            r_tracking  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.fresh) begin
                            r_reading[0] <= i_in.raw_0;
                            r_reading[1] <= i_in.raw_1;
                            r_reading[2] <= i_in.raw_2;
                            r_reading[3] <= i_in.raw_3;
                            r_reading[4] <= i_in.raw_4;
                            r_reading[5] <= i_in.raw_5;
                        end
                        r_ms    <= n_ms;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_hit <= hit;
                    if (r_ms > i_cfg.stale_limit_ms) begin
                        r_stale <= 1'b1;
                        r_cmd_l <= '0;
                        r_cmd_r <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_stale <= 1'b0;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    if (hit_cnt != 3'd0) begin
                        r_err  <= n_err;
                        r_last <= n_err;
                        r_lost <= '0;
                    end else begin
                        r_err  <= '0;
                        r_lost <= n_lost;
                    end
                    r_tracking <= n_track;
                    if (n_track) begin
                        r_state <= S_MIX0;
                    end else begin
                        // spin toward the side the line was last seen
                        if (r_last > 0) begin
                            r_cmd_l <= -spin;
                            r_cmd_r <= spin;
                        end else begin
                            r_cmd_l <= spin;
                            r_cmd_r <= -spin;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_MIX0: r_state <= S_MIX1;
                S_MIX1: r_state <= S_FILT;
                S_FILT: begin
                    r_filt  <= n_filt;
                    r_prev  <= n_filt;
                    r_diff  <= n_diff;
                    r_absf  <= n_absf;
                    r_state <= S_P;
                end
                S_P:  r_state <= S_D;
                S_D:  r_state <= S_B0;
                S_B0: begin
                    r_corr  <= i_acc;
                    r_state <= S_B1;
                end
                S_B1: r_state <= S_L;
                S_L:  r_state <= S_R;
                S_R: begin
                    r_cmd_l <= i_acc;
                    r_state <= S_CMD;
                end
                S_CMD: begin
                    r_cmd_r <= i_acc;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_left_rev   <= r_cmd_l[ACC_W-1];
                        r_left_duty  <= l_pwm;
                        r_right_rev  <= r_cmd_r[ACC_W-1];
                        r_right_duty <= rt_pwm;
                        r_stopped    <= r_stale;
                        r_searching  <= !r_tracking;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/line_follow_pd_steering.sv @@
`default_nettype none
// ============================================================================
// line_follow_pd_steering
// Line-follow PD steering: sensor frame in, two motor commands out.
// ============================================================================
// One request at a time. In track mode the single multiply-accumulate unit
// steps in turn through the smoothing filter, the P and D terms, the base
// slowdown and the two motor sums; search mode and stale frames skip it.
// A new request is taken in the cycle after the result is loaded; the result
// register lets it wait for the sink without holding up the next request.
// Configuration writes are taken at any time and must only be issued while
// the block is idle.
// ============================================================================

module line_follow_pd_steering (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lfpd_in_if.sink     i_in,
    lfpd_out_if.source  o_out,
    lfpd_cfg_if.sink    i_cfg
);

    lfpd_pkg::t_cfg                         cfg;
    lfpd_pkg::t_mac_ctl                     mac_ctl;
    logic signed [lfpd_pkg::ACC_W-1:0]      acc;

    lfpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    lfpd_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .o_acc (acc)
    );

    lfpd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_mac   (mac_ctl),
        .i_acc   (acc)
    );

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready while a request is in progress");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stopped) |->
            (o_out.left_duty == 8'd0 && o_out.right_duty == 8'd0 &&
             !o_out.left_reverse && !o_out.right_reverse))
        else $error("motors driven while frames are stale");

    a_search_spin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.stopped && o_out.searching && o_out.left_duty != 8'd0)
            |-> (o_out.left_reverse != o_out.right_reverse))
        else $error("search mode result is not a spin");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none
// ============================================================================
// tb
// Self-checking bench for the line-follow PD steering block. Sensor ticks go
// in on one channel, motor commands come back on another, and an in-bench
// model of the filter, PD law, search spin and stale-frame cut-off predicts
// every command. Directed ticks come first, then random line-following runs
// under several register settings, random idling on both sides, a long sink
// hold-off and a full drain.
// ============================================================================

module tb;
    import lfpd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 4'd15;
    localparam int MAX_SHOWN = 40;

    typedef struct {
        logic [RAW_W-1:0]     raw [NUM_SENS];
        logic                 fresh;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } sensor_tick_t;

    typedef struct packed {
        logic       left_reverse;
        logic [7:0] left_duty;
        logic       right_reverse;
        logic [7:0] right_duty;
        logic       stopped;
        logic       searching;
    } motor_cmd_t;

    class steering_scoreboard;
        t_cfg                    cfg;
        logic [RAW_W-1:0]        frame [NUM_SENS];
        logic [MS_W-1:0]         ms_idle;
        logic signed [ERR_W-1:0] filt, filt_prev, last_err;
        logic [7:0]              lost;
        bit                      on_line;
        motor_cmd_t              expected_cmds [$];
        int errors, n_checked, n_ticks, n_stale, n_search, n_track, n_writes;

        function void reset_state();
            cfg.line_threshold = 10'd900;
            cfg.prop_gain      = 8'd25;
            cfg.deriv_gain     = 8'd65;
            cfg.smooth_alpha   = 8'd115;
            cfg.turn_slowdown  = 8'd18;
            cfg.base_speed     = 8'd150;
            cfg.search_speed   = 8'd110;
            cfg.stale_limit_ms = 16'd120;
            foreach (frame[i]) frame[i] = '0;
            ms_idle   = '1;
            filt      = '0;
            filt_prev = '0;
            last_err  = '0;
            lost      = '0;
            on_line   = 1'b0;
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            n_writes++;
            case (idx)
                REG_LINE_THRESHOLD: cfg.line_threshold = val[RAW_W-1:0];
                REG_PROP_GAIN:      cfg.prop_gain      = val[GAIN_W-1:0];
                REG_DERIV_GAIN:     cfg.deriv_gain     = val[GAIN_W-1:0];
                REG_SMOOTH_ALPHA:   cfg.smooth_alpha   = val[GAIN_W-1:0];
                REG_TURN_SLOWDOWN:  cfg.turn_slowdown  = val[GAIN_W-1:0];
                REG_BASE_SPEED:     cfg.base_speed     = val[GAIN_W-1:0];
                REG_SEARCH_SPEED:   cfg.search_speed   = val[GAIN_W-1:0];
                REG_STALE_LIMIT_MS: cfg.stale_limit_ms = val;
                default: ;
            endcase
        endfunction

        // magnitude halves away from zero, Q8.8 back to integer steps
        function longint round_q8(longint v);
            longint m;
            m = v < 0 ? -v : v;
            m = (m + 128) >> 8;
            return v < 0 ? -m : m;
        endfunction

        function motor_cmd_t motor_pair(longint lcmd, longint rcmd);
            motor_cmd_t c;
            longint lm, rm, lp, rp;
            lm = lcmd < 0 ? -lcmd : lcmd;
            rm = rcmd < 0 ? -rcmd : rcmd;
            lp = (lm + 128) >> 8;
            rp = (rm * 16 + 1920) / 3840;      // 16/15 trim on the right side
            if (lp > PWM_MAX) lp = PWM_MAX;
            if (rp > PWM_MAX) rp = PWM_MAX;
            c = '0;
            c.left_reverse  = lcmd < 0;
            c.left_duty     = lp[7:0];
            c.right_reverse = rcmd < 0;
            c.right_duty    = rp[7:0];
            return c;
        endfunction

        function void take_tick(sensor_tick_t t);
            motor_cmd_t c;
            int unsigned acc;
            int wsum, hits, mag;
            longint err, alpha, mix, f, diff, corr, base_cmd, spin;
            n_ticks++;
            wsum = 0;
            hits = 0;
            err  = 0;
            if (t.fresh) begin
                foreach (frame[i]) frame[i] = t.raw[i];
                ms_idle = '0;
            end else begin
                acc = ms_idle + t.elapsed_ms;
                ms_idle = acc > 32'hFFFF ? 16'hFFFF : acc[MS_W-1:0];
            end
            if (ms_idle > cfg.stale_limit_ms) begin
                c = '0;
                c.stopped   = 1'b1;
                c.searching = !on_line;
                expected_cmds.push_back(c);
                n_stale++;
                return;
            end
            foreach (frame[i]) begin
                if (frame[i] > cfg.line_threshold) begin
                    wsum += 2 * i - 5;
                    hits++;
                end
            end
            if (hits > 0) begin
                mag = ((wsum < 0 ? -wsum : wsum) * 256 + hits / 2) / hits;
                err = wsum < 0 ? -mag : mag;
                on_line  = 1'b1;
                lost     = '0;
                last_err = err[ERR_W-1:0];
            end else begin
                if (lost < LOST_MAX) lost++;
                if (lost >= LOST_LIMIT) on_line = 1'b0;
            end
            if (!on_line) begin
                spin = cfg.search_speed;
                spin = spin * 256;
                if (last_err > 0) c = motor_pair(-spin, spin);
                else c = motor_pair(spin, -spin);
                n_search++;
            end else begin
                alpha = cfg.smooth_alpha;
                f     = filt;
                mix   = round_q8(alpha * f + (256 - alpha) * err);
                if (mix > 32767) mix = 32767;
                if (mix < -32768) mix = -32768;
                filt = mix[ERR_W-1:0];
                f    = filt;
                diff = f - longint'(filt_prev);
                filt_prev = filt;
                corr = longint'(cfg.prop_gain) * f + longint'(cfg.deriv_gain) * diff;
                base_cmd = longint'(cfg.base_speed) * 256
                         - (f < 0 ? -f : f) * longint'(cfg.turn_slowdown);
                c = motor_pair(base_cmd - corr, base_cmd + corr);
                n_track++;
            end
            c.stopped   = 1'b0;
            c.searching = !on_line;
            expected_cmds.push_back(c);
        endfunction

        task log_mismatch(string what);
            if (errors < MAX_SHOWN) $display("mismatch: %s", what);
            errors++;
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                log_mismatch($sformatf("command %0d %s: got %0d, expected %0d",
                                       n_checked, name, got, want));
        endtask

        task check_cmd(motor_cmd_t got);
            motor_cmd_t want;
            if (expected_cmds.size() == 0) begin
                log_mismatch($sformatf("motor command with nothing outstanding: %p", got));
                return;
            end
            want = expected_cmds.pop_front();
            compare_field("left_reverse", got.left_reverse, want.left_reverse);
            compare_field("left_duty", got.left_duty, want.left_duty);
            compare_field("right_reverse", got.right_reverse, want.right_reverse);
            compare_field("right_duty", got.right_duty, want.right_duty);
            compare_field("stopped", got.stopped, want.stopped);
            compare_field("searching", got.searching, want.searching);
            n_checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    lfpd_in_if  in_if ();
    lfpd_out_if out_if ();
    lfpd_cfg_if cfg_if ();

    line_follow_pd_steering i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    steering_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int n_settings;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // sink side: random back-pressure plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_if.ready = 1'b0;
        end else begin
            out_if.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_cmd(motor_cmd_t'{out_if.left_reverse, out_if.left_duty,
                                      out_if.right_reverse, out_if.right_duty,
                                      out_if.stopped, out_if.searching});
    end

    task automatic send_tick(sensor_tick_t t, bit steady);
        if (!steady) begin
            while ($urandom_range(99) < send_idle_pct) begin
                @(negedge i_clk);
                in_if.valid = 1'b0;
            end
        end
        @(negedge i_clk);
        in_if.valid      = 1'b1;
        in_if.raw_0      = t.raw[0];
        in_if.raw_1      = t.raw[1];
        in_if.raw_2      = t.raw[2];
        in_if.raw_3      = t.raw[3];
        in_if.raw_4      = t.raw[4];
        in_if.raw_5      = t.raw[5];
        in_if.fresh      = t.fresh;
        in_if.elapsed_ms = t.elapsed_ms;
        do @(posedge i_clk); while (!in_if.ready);
        sb.take_tick(t);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.apply_write(idx, val);
    endtask

    // upper data bits carry junk: the block must drop them
    task automatic write_settings(t_cfg c);
        drain_results();
        write_reg(REG_LINE_THRESHOLD, {6'($urandom), c.line_threshold});
        write_reg(REG_PROP_GAIN, {8'($urandom), c.prop_gain});
        write_reg(REG_DERIV_GAIN, {8'($urandom), c.deriv_gain});
        write_reg(REG_SMOOTH_ALPHA, {8'($urandom), c.smooth_alpha});
        write_reg(REG_TURN_SLOWDOWN, {8'($urandom), c.turn_slowdown});
        write_reg(REG_BASE_SPEED, {8'($urandom), c.base_speed});
        write_reg(REG_SEARCH_SPEED, {8'($urandom), c.search_speed});
        write_reg(REG_STALE_LIMIT_MS, c.stale_limit_ms);
        write_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_HI, SPARE_IDX_LO)), 16'($urandom));
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
        n_settings++;
    endtask

    function automatic sensor_tick_t mask_tick(logic [NUM_SENS-1:0] mask, logic fresh,
                                               logic [ELAPSED_W-1:0] el);
        sensor_tick_t t;
        foreach (t.raw[i]) t.raw[i] = mask[i] ? 10'd1023 : 10'd0;
        t.fresh = fresh;
        t.elapsed_ms = el;
        return t;
    endfunction

    function automatic logic [RAW_W-1:0] low_reading();
        return RAW_W'($urandom_range(sb.cfg.line_threshold, 0));
    endfunction

    function automatic logic [RAW_W-1:0] high_reading();
        if (sb.cfg.line_threshold == 10'd1023) return 10'd1023;
        return RAW_W'($urandom_range(1023, sb.cfg.line_threshold + 1));
    endfunction

    function automatic sensor_tick_t random_tick(int kind);
        sensor_tick_t t;
        int pos, span;
        t.fresh = 1'b1;
        t.elapsed_ms = ELAPSED_W'($urandom_range(15));
        foreach (t.raw[i]) t.raw[i] = low_reading();
        if (kind < 68) begin
            pos  = $urandom_range(NUM_SENS - 1);
            span = $urandom_range(3, 1);
            foreach (t.raw[i])
                if (i >= pos && i < pos + span) t.raw[i] = high_reading();
        end else if (kind < 76) begin
        end else if (kind < 86) begin
            t.fresh = 1'b0;
            t.elapsed_ms = ELAPSED_W'($urandom_range(40));
        end else if (kind < 91) begin
            t.fresh = 1'b0;
            t.elapsed_ms = ELAPSED_W'($urandom);
        end else begin
            foreach (t.raw[i]) t.raw[i] = RAW_W'($urandom);
            t.fresh = 1'($urandom);
            t.elapsed_ms = ELAPSED_W'($urandom);
        end
        return t;
    endfunction

    task automatic run_phase(int n_ticks);
        int sent, kind, run_len;
        sensor_tick_t t;
        sent = 0;
        while (sent < n_ticks) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                // line lost for a few ticks: drives the block into search
                run_len = $urandom_range(6, 3);
                repeat (run_len) begin
                    t = random_tick(70);
                    send_tick(t, 1'b0);
                end
                sent += run_len;
            end else begin
                t = random_tick($urandom_range(99));
                send_tick(t, 1'b0);
                sent++;
            end
        end
    endtask

    function automatic int skewed(int hi);
        case ($urandom_range(3))
            0:       return 0;
            1:       return hi;
            default: return $urandom_range(hi);
        endcase
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        c.line_threshold = ($urandom_range(9) == 0) ? RAW_W'($urandom)
                                                    : RAW_W'($urandom_range(1000, 300));
        c.prop_gain      = GAIN_W'(skewed(255));
        c.deriv_gain     = GAIN_W'(skewed(255));
        c.smooth_alpha   = GAIN_W'(skewed(255));
        c.turn_slowdown  = GAIN_W'(skewed(255));
        c.base_speed     = GAIN_W'(skewed(255));
        c.search_speed   = GAIN_W'(skewed(255));
        c.stale_limit_ms = ($urandom_range(9) == 0) ? MS_W'(skewed(65535))
                                                    : MS_W'($urandom_range(300, 20));
        return c;
    endfunction

    initial begin
        t_cfg         c;
        t_cfg         defaults;
        sensor_tick_t t;
        sb = new;
        sb.reset_state();
        send_idle_pct = 11;
        recv_idle_pct = 73;
        hold_request  = 0;
        hold_left     = 0;
        n_settings    = 0;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.raw_0      = '0;
        in_if.raw_1      = '0;
        in_if.raw_2      = '0;
        in_if.raw_3      = '0;
        in_if.raw_4      = '0;
        in_if.raw_5      = '0;
        in_if.fresh      = 1'b0;
        in_if.elapsed_ms = '0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // idle counter must saturate, not wrap, after reset
        defaults = sb.cfg;
        c = defaults;
        c.stale_limit_ms = 16'd300;
        write_settings(c);
        send_tick(mask_tick(6'b000000, 1'b0, 8'd255), 1'b0);
        send_tick(mask_tick(6'b111111, 1'b0, 8'd0), 1'b0);
        write_settings(defaults);

        send_tick(mask_tick(6'b000000, 1'b1, 8'd0), 1'b0);
        send_tick(mask_tick(6'b111111, 1'b1, 8'd3), 1'b0);
        send_tick(mask_tick(6'b000001, 1'b1, 8'd5), 1'b0);
        send_tick(mask_tick(6'b100000, 1'b1, 8'd5), 1'b0);
        send_tick(mask_tick(6'b110000, 1'b1, 8'd5), 1'b0);
        send_tick(mask_tick(6'b111000, 1'b1, 8'd5), 1'b0);
        send_tick(mask_tick(6'b001110, 1'b1, 8'd5), 1'b0);
        send_tick(mask_tick(6'b011111, 1'b1, 8'd5), 1'b0);
        t = mask_tick(6'b000000, 1'b1, 8'd5);
        foreach (t.raw[i]) t.raw[i] = 10'd900;
        t.raw[4] = 10'd901;
        send_tick(t, 1'b0);
        repeat (3) send_tick(mask_tick(6'b000000, 1'b1, 8'd8), 1'b0);
        send_tick(mask_tick(6'b000001, 1'b1, 8'd8), 1'b0);
        repeat (3) send_tick(mask_tick(6'b000000, 1'b1, 8'd8), 1'b0);
        send_tick(mask_tick(6'b111111, 1'b0, 8'd0), 1'b0);
        send_tick(mask_tick(6'b000100, 1'b1, 8'd8), 1'b0);
        send_tick(mask_tick(6'b000000, 1'b0, 8'd100), 1'b0);
        send_tick(mask_tick(6'b000000, 1'b0, 8'd21), 1'b0);
        send_tick(mask_tick(6'b001000, 1'b1, 8'd1), 1'b0);

        run_phase(100);
        // sink stalls for a long stretch while ticks keep coming
        hold_request = 400;
        repeat (8) begin
            t = random_tick($urandom_range(67));
            send_tick(t, 1'b1);
        end
        run_phase(100);

        c.line_threshold = 10'd0;
        c.prop_gain      = 8'd255;
        c.deriv_gain     = 8'd255;
        c.smooth_alpha   = 8'd255;
        c.turn_slowdown  = 8'd255;
        c.base_speed     = 8'd255;
        c.search_speed   = 8'd255;
        c.stale_limit_ms = 16'hFFFF;
        write_settings(c);
        run_phase(60);

        c = '0;
        c.line_threshold = 10'd1023;
        write_settings(c);
        run_phase(40);

        send_idle_pct = 73;
        recv_idle_pct = 11;
        repeat (3) begin
            write_settings(random_settings());
            run_phase(35);
            drain_results();
            run_phase(35);
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) begin
            write_settings(random_settings());
            run_phase(60);
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("%0d sensor ticks checked: %0d stale, %0d searching, %0d tracking",
                 sb.n_checked, sb.n_stale, sb.n_search, sb.n_track);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 sb.n_writes, n_settings, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/lfpd_pkg.sv
hw/rtl/lfpd_if.sv
hw/rtl/lfpd_cfg_regs.sv
hw/rtl/lfpd_mac.sv
hw/rtl/lfpd_seq.sv
hw/rtl/line_follow_pd_steering.sv
bench/tb.sv
